@@ rtl/rhht_pkg.sv @@
// Package for the Robin Hood hash table: widths, request and status codes,
// and the datapath command and status structs. Depends on nothing.
package rhht_pkg;
    localparam int SLOTS_DEFAULT = 16;
    localparam int DIST_W = 5;
    localparam logic [4:0] DIST_MAX = 5'd31;
    localparam int HASH_W = 32;
    localparam int VAL_W = 64;
    localparam int TYPE_W = 4;
    localparam int IDX_W = 4;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic load;      // latch request, set cursor to home slot
        logic swap;      // write carried entry at cursor, carry resident
        logic place;     // write carried entry at cursor as new valid entry
        logic advance;   // step cursor and distance
        logic clear;     // clear valid bit at cursor, decrement count
        logic hit;       // capture lookup/delete hit result
        logic miss;      // capture not found result
        logic full;      // capture table full result
    } rhht_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       cur_valid;  // valid bit of cursor slot
        logic       closer;     // resident distance < carried distance
        logic       match;      // resident valid and hash equal
        logic       is_full;    // count >= slots
        logic       scan_done;  // scan budget spent
        logic       probe_done; // insert step budget spent
    } rhht_stat_t;
endpackage

@@ rtl/rhht_ram.sv @@
// Generic single-port RAM with registered read. Depends on nothing.
module rhht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/rhht_datapath.sv @@
// Datapath of the Robin Hood hash table: slot RAM, valid bits, cursor,
// carried entry, counters and result register. Uses rhht_pkg and rhht_ram.
module rhht_datapath #(
    parameter int SLOTS = rhht_pkg::SLOTS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rhht_pkg::rhht_cmd_t           cmd,
    output rhht_pkg::rhht_stat_t          stat,
    input  logic [1:0]                    req_type,
    input  logic [rhht_pkg::HASH_W-1:0]   key_hash,
    input  logic [rhht_pkg::VAL_W-1:0]    entry_value,
    input  logic [rhht_pkg::TYPE_W-1:0]   entry_type,
    output logic [1:0]                    status,
    output logic [rhht_pkg::VAL_W-1:0]    out_value,
    output logic [rhht_pkg::TYPE_W-1:0]   out_type,
    output logic [rhht_pkg::IDX_W-1:0]    slot_index
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int ENT_W = rhht_pkg::HASH_W + rhht_pkg::VAL_W + rhht_pkg::TYPE_W
                           + rhht_pkg::DIST_W;
    localparam int LIM0 = (SLOTS / 5 > 31) ? 31 : SLOTS / 5;
    localparam int SW = $clog2(SLOTS + 1);

    logic [1:0]                  req_reg;
    logic [rhht_pkg::HASH_W-1:0] key_reg;
    logic [rhht_pkg::HASH_W-1:0] ch_reg;
    logic [rhht_pkg::VAL_W-1:0]  cv_reg;
    logic [rhht_pkg::TYPE_W-1:0] ct_reg;
    logic [rhht_pkg::DIST_W-1:0] cd_reg;
    logic [AW-1:0]               cur_reg;
    logic [AW-1:0]               placed_reg;
    logic                        placed_set_reg;
    logic [SW-1:0]               steps_reg;
    logic [SLOTS-1:0]            valid_reg;
    logic [CW-1:0]               count_reg;
    logic [rhht_pkg::DIST_W-1:0] limit_reg;
    logic [ENT_W-1:0]            rdata;
    logic [ENT_W-1:0]            wdata;
    logic                        we;
    logic [AW-1:0]               home;
    logic [AW-1:0]               cur_inc;
    logic [rhht_pkg::DIST_W-1:0] cd_inc;
    logic [rhht_pkg::HASH_W-1:0] r_hash;
    logic [rhht_pkg::VAL_W-1:0]  r_val;
    logic [rhht_pkg::TYPE_W-1:0] r_type;
    logic [rhht_pkg::DIST_W-1:0] r_dist;
    logic [5:0]                  scan_n;
    logic [SW+1:0]               scan_lim;

    assign home = AW'(key_hash % SLOTS);
    assign cur_inc = (32'(cur_reg) + 32'd1 >= 32'(SLOTS)) ? '0 : cur_reg + AW'(1);
    assign {r_hash, r_val, r_type, r_dist} = rdata;
    assign we = cmd.swap || cmd.place;
    assign wdata = {ch_reg, cv_reg, ct_reg, cd_reg};
    assign scan_n = {1'b0, limit_reg} + 6'd1;
    assign scan_lim = (32'(scan_n) > 32'(SLOTS)) ? (SW+2)'(SLOTS) : (SW+2)'(scan_n);

    always_comb begin
        logic [rhht_pkg::DIST_W-1:0] d;
        d = cmd.swap ? r_dist : cd_reg;
        cd_inc = (d < rhht_pkg::DIST_MAX) ? d + 1'b1 : d;
    end

    rhht_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ram (
        .aclk (aclk), .we (we), .addr (cur_reg), .wdata (wdata), .rdata (rdata)
    );

    assign stat.req        = req_reg;
    assign stat.cur_valid  = valid_reg[cur_reg];
    assign stat.closer     = r_dist < cd_reg;
    assign stat.match      = valid_reg[cur_reg] && (r_hash == key_reg);
    assign stat.is_full    = 32'(count_reg) >= 32'(SLOTS);
    assign stat.scan_done  = (SW+2)'(steps_reg) >= scan_lim;
    assign stat.probe_done = 32'(steps_reg) >= 32'(SLOTS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            limit_reg <= rhht_pkg::DIST_W'(LIM0);
        end else begin
            if (cmd.place) begin
                valid_reg[cur_reg] <= 1'b1;
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.clear) begin
                valid_reg[cur_reg] <= 1'b0;
                if (count_reg != '0) count_reg <= count_reg - CW'(1);
            end
            // Only an insert's carried distance can raise the probe limit.
            if (cmd.advance && req_reg == rhht_pkg::REQ_INSERT && cd_inc > limit_reg)
                limit_reg <= cd_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= req_type;
            key_reg <= key_hash;
            ch_reg <= key_hash;
            cv_reg <= entry_value;
            ct_reg <= entry_type;
            cd_reg <= rhht_pkg::DIST_W'(1);
            cur_reg <= home;
            steps_reg <= '0;
            placed_set_reg <= 1'b0;
        end
        if (cmd.swap) begin
            ch_reg <= r_hash;
            cv_reg <= r_val;
            ct_reg <= r_type;
            if (!placed_set_reg) begin
                placed_reg <= cur_reg;
                placed_set_reg <= 1'b1;
            end
        end
        if (cmd.advance) begin
            cd_reg <= cd_inc;
            cur_reg <= cur_inc;
            steps_reg <= steps_reg + SW'(1);
        end
        if (cmd.place) begin
            status <= rhht_pkg::ST_OK;
            out_value <= '0;
            out_type <= '0;
            slot_index <= rhht_pkg::IDX_W'(placed_set_reg ? placed_reg : cur_reg);
        end
        if (cmd.hit) begin
            status <= rhht_pkg::ST_OK;
            out_value <= (req_reg == rhht_pkg::REQ_LOOKUP) ? r_val : '0;
            out_type <= (req_reg == rhht_pkg::REQ_LOOKUP) ? r_type : '0;
            slot_index <= rhht_pkg::IDX_W'(cur_reg);
        end
        if (cmd.miss || cmd.full) begin
            status <= cmd.full ? rhht_pkg::ST_FULL : rhht_pkg::ST_NOT_FOUND;
            out_value <= '0;
            out_type <= '0;
            slot_index <= '0;
        end
    end
endmodule

@@ rtl/rhht_ctrl.sv @@
// Controller state machine of the Robin Hood hash table: sequences probe
// steps and the handshakes. Uses rhht_pkg.
module rhht_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  rhht_pkg::rhht_stat_t stat,
    output rhht_pkg::rhht_cmd_t  cmd
);
    typedef enum logic [2:0] {IDLE, DECODE, READ, PROBE, OUTPUT} state_t;
    state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    state_next = DECODE;
                end
            end
            DECODE: begin
                if (stat.req == rhht_pkg::REQ_INSERT && stat.is_full) begin
                    cmd.full = 1'b1;
                    state_next = OUTPUT;
                end else if (stat.req == rhht_pkg::REQ_INSERT
                             || stat.req == rhht_pkg::REQ_LOOKUP
                             || stat.req == rhht_pkg::REQ_DELETE) begin
                    state_next = READ;
                end else begin
                    cmd.miss = 1'b1;
                    state_next = OUTPUT;
                end
            end
            READ: begin
                state_next = PROBE;
            end
            PROBE: begin
                if (stat.req == rhht_pkg::REQ_INSERT) begin
                    if (stat.cur_valid && !stat.probe_done) begin
                        cmd.swap = stat.closer;
                        cmd.advance = 1'b1;
                        state_next = READ;
                    end else begin
                        cmd.place = 1'b1;
                        state_next = OUTPUT;
                    end
                end else if (stat.scan_done) begin
                    cmd.miss = 1'b1;
                    state_next = OUTPUT;
                end else if (stat.match) begin
                    cmd.hit = 1'b1;
                    cmd.clear = (stat.req == rhht_pkg::REQ_DELETE);
                    state_next = OUTPUT;
                end else begin
                    cmd.advance = 1'b1;
                    state_next = READ;
                end
            end
            OUTPUT: begin
                m_valid_next = 1'b1;
                state_next = IDLE;
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule

@@ rtl/robin_hood_hash_table.sv @@
// Top level of the Robin Hood hash table: controller plus datapath.
// Uses rhht_pkg, rhht_ctrl and rhht_datapath.
//
// Usage: each request transaction on the s_ channel carries a request type
// (insert, lookup, delete), a precomputed 32-bit key hash, and for inserts a
// 64-bit payload and a 4-bit type tag. Exactly one result transaction follows
// on the m_ channel with a status, the payload and tag found by a lookup and
// the slot index found, written or cleared.
// Timing: after a request is accepted the controller passes DECODE, then a
// READ and a PROBE state per probe step, then OUTPUT, which raises m_valid;
// each step reads the single-port slot RAM and then decides on its data. An
// insert takes one step per slot visited, up to SLOTS; a lookup or delete
// takes one step per slot up to the match, and a miss takes probe_limit+1
// slots (at most SLOTS) plus one more step. A full-table insert or an unknown
// request goes from DECODE straight to OUTPUT. One request is in flight at a
// time: the next one is accepted once the controller is back in IDLE and the
// receiver takes the waiting result, at the earliest as m_valid rises.
// Reset clears all valid bits, the entry count and the handshakes and loads
// probe_limit with SLOTS/5, capped at 31; no clearing pass is needed, since
// slot contents are read only behind a set valid bit.
module robin_hood_hash_table #(
    parameter int SLOTS = rhht_pkg::SLOTS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_req_type,
    input  logic [rhht_pkg::HASH_W-1:0] s_key_hash,
    input  logic [rhht_pkg::VAL_W-1:0]  s_entry_value,
    input  logic [rhht_pkg::TYPE_W-1:0] s_entry_type,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [rhht_pkg::VAL_W-1:0]  m_out_value,
    output logic [rhht_pkg::TYPE_W-1:0] m_out_type,
    output logic [rhht_pkg::IDX_W-1:0]  m_slot_index
);
    rhht_pkg::rhht_cmd_t  cmd;
    rhht_pkg::rhht_stat_t stat;

    // The controller only steps the datapath; all table state lives below.
    rhht_ctrl u_ctrl (
        .aclk (aclk), .aresetn (aresetn), .s_valid (s_valid), .s_ready (s_ready),
        .m_valid (m_valid), .m_ready (m_ready), .stat (stat), .cmd (cmd)
    );

    rhht_datapath #(.SLOTS(SLOTS)) u_dp (
        .aclk (aclk), .aresetn (aresetn), .cmd (cmd), .stat (stat),
        .req_type (s_req_type), .key_hash (s_key_hash),
        .entry_value (s_entry_value), .entry_type (s_entry_type),
        .status (m_status), .out_value (m_out_value), .out_type (m_out_type),
        .slot_index (m_slot_index)
    );
endmodule

@@ rtl/rhht_checker.sv @@
// Port-level checker for the Robin Hood hash table, bound to the top level.
// Uses rhht_pkg.
module rhht_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [1:0]                  m_status,
    input logic [rhht_pkg::VAL_W-1:0]  m_out_value,
    input logic [rhht_pkg::IDX_W-1:0]  m_slot_index
);
    // After a request is accepted, no new request is taken the next cycle.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while one is in flight");

    // A result is never new while the previous one is stalled.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)
                                   && $stable(m_slot_index)))
        else $error("stalled result changed");

    // Failed results carry zero slot and payload.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != rhht_pkg::ST_OK) |->
        (m_slot_index == '0 && m_out_value == '0))
        else $error("failed result carries data");

    // Status is one of the defined codes.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status != 2'd3))
        else $error("undefined status");
endmodule

bind robin_hood_hash_table rhht_checker u_rhht_checker (
    .aclk (aclk), .aresetn (aresetn), .s_valid (s_valid), .s_ready (s_ready),
    .m_valid (m_valid), .m_ready (m_ready), .m_status (m_status),
    .m_out_value (m_out_value), .m_slot_index (m_slot_index)
);
